/* hdl/tti_pkg.sv */
// ----------------------------------------------------------------------------
// tti_pkg
// Shared constants and types for the thermocouple tracking interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package tti_pkg;

  localparam int TTI_POINTS     = 70;
  localparam int TTI_CURVES     = 2;
  localparam int TTI_STEP_SCALE = 10000;

  localparam int POS_W     = 7;
  localparam int CODE_W    = 16;
  localparam int SAMPLE_W  = 17;
  localparam int IDX_W     = 7;
  localparam int TEMP_W    = 32;

  localparam logic [POS_W-1:0] POS_RESET = 7'd3;

  localparam logic CMD_CONVERT = 1'b0;
  localparam logic CMD_LOAD    = 1'b1;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_RD     = 9'b000000010,
    S_CMP    = 9'b000000100,
    S_RD_TOP = 9'b000001000,
    S_RD_BOT = 9'b000010000,
    S_MUL    = 9'b000100000,
    S_DIV    = 9'b001000000,
    S_FIN    = 9'b010000000,
    S_SPARE  = 9'b100000000
  } tti_state_t;

endpackage

`default_nettype wire

/* hdl/thermocouple_tracking_interpolator_top.sv */
// ----------------------------------------------------------------------------
// Flow: a conversion reads and compares k table points, k being the points the search visits
// (1 to POINTS-1), then runs MAG_W (31) divider steps, none on a flat segment. A new request
// is refused (in_stall) until the result is taken into the output register; loads need idle.
// Reset: synchronous, active low; search position 3, curve J, memory contents undefined.
// ----------------------------------------------------------------------------
// Thermocouple tracking interpolator
// Tracking table search and linear interpolation to thousandths of a degree.
// ----------------------------------------------------------------------------
`default_nettype none

module thermocouple_tracking_interpolator_top
  import tti_pkg::*;
#(
  parameter int POINTS     = TTI_POINTS,
  parameter int CURVES     = TTI_CURVES,
  parameter int STEP_SCALE = TTI_STEP_SCALE
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,

  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic                       cfg_couple_type,

  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_cmd,
  input  wire logic                       in_table_id,
  input  wire logic [IDX_W-1:0]           in_entry_index,
  input  wire logic [CODE_W-1:0]          in_entry_value,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,

  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [TEMP_W-1:0]        out_temperature,
  output logic                            out_clamped_high,
  output logic                            out_clamped_low
);

  localparam int DEPTH    = CURVES * POINTS;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int SW       = $clog2(STEP_SCALE + 1);
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int PROD_W   = DIFF_W + SW + 1;
  localparam int MAG_W    = SAMPLE_W + SW;
  localparam int DEN_W    = CODE_W;
  localparam int PTERM_W  = POS_W + SW;
  localparam int SUM_W    = (MAG_W + 2 > TEMP_W + 1) ? MAG_W + 2 : TEMP_W + 1;
  localparam int CNT_W    = $clog2(MAG_W + 1);
  localparam int LAST_CRV = CURVES - 1;

  localparam logic [POS_W-1:0]         POS_TOP  = POS_W'(POINTS - 1);
  localparam logic [POS_W-1:0]         POS_ONE  = POS_W'(1);
  localparam logic signed [SW:0]       SCALE_S  = (SW + 1)'(STEP_SCALE);
  localparam logic signed [SUM_W-1:0]  SAT_MAX  = SUM_W'(signed'(32'h7fff_ffff));
  localparam logic signed [SUM_W-1:0]  SAT_MIN  = SUM_W'(signed'(32'h8000_0000));

  tti_state_t state_r, state_nxt;

  logic [POS_W-1:0]         pos_r, pos_nxt;
  logic                     couple_type_r, couple_type_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic [ADDR_W-1:0]        base_r, base_nxt;
  logic signed [SAMPLE_W-1:0] x_r, x_nxt;
  logic                     first_r, first_nxt;
  logic                     up_r, up_nxt;
  logic                     hi_r, hi_nxt;
  logic                     lo_r, lo_nxt;
  logic [CODE_W-1:0]        top_r, top_nxt;
  logic [PTERM_W-1:0]       pterm_r, pterm_nxt;
  logic [MAG_W-1:0]         q_r, q_nxt;
  logic [DEN_W-1:0]         rem_r, rem_nxt;
  logic [DEN_W-1:0]         den_r, den_nxt;
  logic                     neg_r, neg_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic signed [TEMP_W-1:0] temp_r, temp_nxt;
  logic                     ohi_r, ohi_nxt;
  logic                     olo_r, olo_nxt;

  logic [CODE_W-1:0]        mem [DEPTH];
  logic [CODE_W-1:0]        rd_data_r;
  logic [ADDR_W-1:0]        rd_addr;
  logic [POS_W-1:0]         rd_pos;
  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;

  logic                     in_acc;
  logic                     slot_free;
  logic                     x_ge, x_le, up_now;
  logic [1:0]               curve_sel;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] mul_a;
  logic signed [PROD_W-1:0] prod;
  logic signed [SAMPLE_W-1:0] den_s;
  logic [DEN_W:0]           rem_sh;
  logic signed [MAG_W:0]    q_s;
  logic signed [SUM_W-1:0]  sum;

  assign cfg_ready        = 1'b1;
  assign in_stall         = (state_r != S_IDLE);
  assign in_acc           = in_valid & ~in_stall;
  assign slot_free        = ~out_valid_r | ~out_stall;
  assign out_valid        = out_valid_r;
  assign out_temperature  = temp_r;
  assign out_clamped_high = ohi_r;
  assign out_clamped_low  = olo_r;

  assign rd_pos  = (state_r == S_RD_BOT) ? pos_r - POS_ONE : pos_r;
  assign rd_addr = base_r + ADDR_W'(rd_pos);

  assign wr_en   = in_acc && (in_cmd == CMD_LOAD) && (32'(in_table_id) < CURVES)
                   && (32'(in_entry_index) < POINTS);
  assign wr_addr = ADDR_W'(32'(in_table_id) * POINTS + 32'(in_entry_index));

  assign curve_sel = (32'(couple_type_r) < CURVES) ? {1'b0, couple_type_r}
                                                   : 2'(LAST_CRV);

  assign x_ge   = $signed({x_r[SAMPLE_W-1], x_r}) >= $signed({2'b00, rd_data_r});
  assign x_le   = $signed({x_r[SAMPLE_W-1], x_r}) <= $signed({2'b00, rd_data_r});
  assign up_now = first_r ? x_ge : up_r;

  assign diff  = DIFF_W'(x_r) - signed'({2'b00, top_r});
  assign mul_a = (state_r == S_RD_TOP) ? signed'(DIFF_W'(pos_r)) : diff;
  assign prod  = mul_a * SCALE_S;
  assign den_s = signed'({1'b0, top_r}) - signed'({1'b0, rd_data_r});

  assign rem_sh = {rem_r, q_r[MAG_W-1]};
  assign q_s    = neg_r ? -signed'({1'b0, q_r}) : signed'({1'b0, q_r});
  assign sum    = SUM_W'(q_s) + signed'(SUM_W'(pterm_r));

  always_comb begin
    state_nxt       = state_r;
    pos_nxt         = pos_r;
    couple_type_nxt = couple_type_r;
    out_valid_nxt   = out_valid_r & out_stall;
    base_nxt        = base_r;
    x_nxt           = x_r;
    first_nxt       = first_r;
    up_nxt          = up_r;
    hi_nxt          = hi_r;
    lo_nxt          = lo_r;
    top_nxt         = top_r;
    pterm_nxt       = pterm_r;
    q_nxt           = q_r;
    rem_nxt         = rem_r;
    den_nxt         = den_r;
    neg_nxt         = neg_r;
    cnt_nxt         = cnt_r;
    temp_nxt        = temp_r;
    ohi_nxt         = ohi_r;
    olo_nxt         = olo_r;

    if (cfg_valid && cfg_ready) begin
      couple_type_nxt = cfg_couple_type;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_cmd == CMD_CONVERT)) begin
          x_nxt     = in_sample;
          base_nxt  = ADDR_W'(32'(curve_sel) * POINTS);
          first_nxt = 1'b1;
          hi_nxt    = 1'b0;
          lo_nxt    = 1'b0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        first_nxt = 1'b0;
        up_nxt    = up_now;
        if (up_now) begin
          if (x_ge) begin
            if (pos_r == POS_TOP) begin
              x_nxt     = signed'(SAMPLE_W'(rd_data_r));
              hi_nxt    = 1'b1;
              state_nxt = S_RD_TOP;
            end else begin
              pos_nxt   = pos_r + POS_ONE;
              state_nxt = S_RD;
            end
          end else begin
            pos_nxt   = pos_r - POS_ONE;
            state_nxt = S_RD_TOP;
          end
        end else begin
          if (x_le) begin
            if (pos_r == POS_ONE) begin
              lo_nxt    = 1'b1;
              state_nxt = S_RD_TOP;
            end else begin
              pos_nxt   = pos_r - POS_ONE;
              state_nxt = S_RD;
            end
          end else begin
            state_nxt = S_RD_TOP;
          end
        end
      end
      S_RD_TOP: begin
        pterm_nxt = prod[PTERM_W-1:0];
        state_nxt = S_RD_BOT;
      end
      S_RD_BOT: begin
        top_nxt   = rd_data_r;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        q_nxt   = prod[PROD_W-1] ? MAG_W'(-prod) : MAG_W'(prod);
        den_nxt = den_s[SAMPLE_W-1] ? DEN_W'(-den_s) : DEN_W'(den_s);
        neg_nxt = prod[PROD_W-1] ^ den_s[SAMPLE_W-1];
        rem_nxt = '0;
        cnt_nxt = CNT_W'(MAG_W);
        if (den_s == '0) begin
          q_nxt     = '0;
          neg_nxt   = 1'b0;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (rem_sh >= {1'b0, den_r}) begin
          rem_nxt = DEN_W'(rem_sh - {1'b0, den_r});
          q_nxt   = {q_r[MAG_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[DEN_W-1:0];
          q_nxt   = {q_r[MAG_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          if (sum > SAT_MAX) begin
            temp_nxt = SAT_MAX[TEMP_W-1:0];
          end else if (sum < SAT_MIN) begin
            temp_nxt = SAT_MIN[TEMP_W-1:0];
          end else begin
            temp_nxt = sum[TEMP_W-1:0];
          end
          ohi_nxt       = hi_r;
          olo_nxt       = lo_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      pos_r         <= POS_RESET;
      couple_type_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      pos_r         <= pos_nxt;
      couple_type_r <= couple_type_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r  <= base_nxt;
    x_r     <= x_nxt;
    first_r <= first_nxt;
    up_r    <= up_nxt;
    hi_r    <= hi_nxt;
    lo_r    <= lo_nxt;
    top_r   <= top_nxt;
    pterm_r <= pterm_nxt;
    q_r     <= q_nxt;
    rem_r   <= rem_nxt;
    den_r   <= den_nxt;
    neg_r   <= neg_nxt;
    cnt_r   <= cnt_nxt;
    temp_r  <= temp_nxt;
    ohi_r   <= ohi_nxt;
    olo_r   <= olo_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_entry_value;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// Thermocouple tracking interpolator testbench
// Loads both voltage curves and walks a table of directed requests, then
// random request streams under three curve selections. Each conversion is
// predicted by a local tracking-search and interpolation model (or a directed
// row's fixed reading) and checked field by field against the block's results in
// order. Requests idle at random; results stall at random and hold off once for a long stretch.
// ----------------------------------------------------------------------------

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tti_pkg::*;

  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 200;
  localparam int NPTS          = TTI_POINTS;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic                     clamped_high;
    logic                     clamped_low;
  } reading_t;

  typedef struct packed {
    logic                       cmd;
    logic                       table_id;
    logic [IDX_W-1:0]           entry_index;
    logic [CODE_W-1:0]          entry_value;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       fixed;
    reading_t                   lit;
  } request_t;

  localparam reading_t NO_LIT = '0;
  localparam reading_t AT_TOP = '{32'sd690000, 1'b1, 1'b0};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_couple_type = 1'b0;

  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_cmd = CMD_CONVERT;
  logic                       in_table_id = 1'b0;
  logic [IDX_W-1:0]           in_entry_index = '0;
  logic [CODE_W-1:0]          in_entry_value = '0;
  logic signed [SAMPLE_W-1:0] in_sample = '0;

  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [TEMP_W-1:0]   out_temperature;
  logic                       out_clamped_high;
  logic                       out_clamped_low;

  thermocouple_tracking_interpolator_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_couple_type  (cfg_couple_type),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_table_id      (in_table_id),
    .in_entry_index   (in_entry_index),
    .in_entry_value   (in_entry_value),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_temperature  (out_temperature),
    .out_clamped_high (out_clamped_high),
    .out_clamped_low  (out_clamped_low)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Predictor state
  logic [CODE_W-1:0] curve_mem [TTI_CURVES*NPTS] = '{default: '0};
  logic [POS_W-1:0]  track_pos = POS_RESET;
  logic              sel_curve = 1'b0;

  // Stimulus-side view of the curves, used to aim samples
  int   gen_pts [TTI_CURVES*NPTS] = '{default: 0};
  logic gen_sel = 1'b0;
  int   last_sample = 0;

  request_t req_q [$];
  reading_t reading_q [$];
  int       reqs_pending = 0;
  int       tx_count = 0;
  int       rx_count = 0;
  int       mismatch_count = 0;
  int       quiet_cycles = 0;
  int       hold_left = 0;
  bit       held_off = 1'b0;
  request_t cur_req;
  reading_t predicted;
  reading_t want;

  request_t directed_rows [23] = '{
    '{CMD_CONVERT, 1'b0, 7'd0,   16'd0,     17'sd3700,  1'b1, '{32'sd30000, 1'b0, 1'b0}},
    '{CMD_CONVERT, 1'b0, 7'd0,   16'd0,     17'sd4600,  1'b1, '{32'sd40000, 1'b0, 1'b0}},
    '{CMD_CONVERT, 1'b0, 7'd0,   16'd0,     17'sd4150,  1'b0, NO_LIT},
    '{CMD_CONVERT, 1'b0, 7'd0,   16'd0,     17'sd65535, 1'b1, AT_TOP},
    '{CMD_CONVERT, 1'b0, 7'd0,   16'd0,     17'sd63100, 1'b1, AT_TOP},
    '{CMD_CONVERT, 1'b0, 7'd0,   16'd0,     17'sd63099, 1'b0, NO_LIT},
    '{CMD_CONVERT, 1'b0, 7'd0,   16'd0,     17'h10000,  1'b0, NO_LIT},
    '{CMD_CONVERT, 1'b0, 7'd0,   16'd0,     17'sd1000,  1'b1, '{32'sd0, 1'b0, 1'b1}},
    '{CMD_CONVERT, 1'b0, 7'd0,   16'd0,     17'sd0,     1'b0, NO_LIT},
    '{CMD_CONVERT, 1'b0, 7'd0,   16'd0,     17'sd27100, 1'b1, '{32'sd300000, 1'b0, 1'b0}},
    '{CMD_CONVERT, 1'b0, 7'd0,   16'd0,     17'sd44850, 1'b0, NO_LIT},
    '{CMD_CONVERT, 1'b0, 7'd0,   16'd0,     17'sd65535, 1'b1, AT_TOP},
    '{CMD_CONVERT, 1'b0, 7'd0,   16'd0,     17'sd44850, 1'b0, NO_LIT},
    '{CMD_CONVERT, 1'b0, 7'd0,   16'd0,     17'sd44800, 1'b0, NO_LIT},
    '{CMD_LOAD,    1'b0, 7'd127, 16'd65535, 17'sd0,     1'b0, NO_LIT},
    '{CMD_LOAD,    1'b0, 7'd70,  16'd0,     17'sd0,     1'b0, NO_LIT},
    '{CMD_LOAD,    1'b1, 7'd0,   16'd0,     17'sd0,     1'b0, NO_LIT},
    '{CMD_CONVERT, 1'b0, 7'd0,   16'd0,     17'sd65535, 1'b1, AT_TOP},
    '{CMD_LOAD,    1'b0, 7'd69,  16'd65535, 17'sd0,     1'b0, NO_LIT},
    '{CMD_CONVERT, 1'b0, 7'd0,   16'd0,     17'sd65535, 1'b1, AT_TOP},
    '{CMD_CONVERT, 1'b0, 7'd0,   16'd0,     17'sd64000, 1'b0, NO_LIT},
    '{CMD_LOAD,    1'b0, 7'd69,  16'd63100, 17'sd0,     1'b0, NO_LIT},
    '{CMD_CONVERT, 1'b0, 7'd0,   16'd0,     17'h1FFFF,  1'b0, NO_LIT}
  };

  function automatic longint curve_point(input int base, input longint idx);
    if (idx < 0 || idx >= NPTS) return 0;
    return longint'(curve_mem[base + int'(idx)]);
  endfunction

  function automatic reading_t convert_voltage(input logic signed [SAMPLE_W-1:0] smp);
    int       base;
    int       n;
    longint   pos;
    longint   x;
    longint   top;
    longint   den;
    longint   t;
    reading_t r;
    base = int'(sel_curve) * NPTS;
    pos = longint'(track_pos);
    x = smp;
    r = '0;
    if (x >= curve_point(base, pos)) begin
      for (n = 0; n < NPTS; n++) begin
        if (x >= curve_point(base, pos)) begin
          pos++;
        end else begin
          pos--;
          break;
        end
        if (pos > NPTS - 1) begin
          x = curve_point(base, NPTS - 1);
          pos = NPTS - 1;
          r.clamped_high = 1'b1;
          break;
        end
      end
    end else begin
      for (n = 0; n < NPTS; n++) begin
        if (pos < 1) begin
          pos = 1;
          r.clamped_low = 1'b1;
          break;
        end
        if (x <= curve_point(base, pos)) pos--;
        else break;
      end
    end
    if (pos < 1) pos = 1;
    if (pos > NPTS - 1) pos = NPTS - 1;
    track_pos = pos[POS_W-1:0];
    top = curve_point(base, pos);
    den = top - curve_point(base, pos - 1);
    t = pos * TTI_STEP_SCALE;
    if (den != 0) t += ((x - top) * TTI_STEP_SCALE) / den;
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    if (t < -64'sd2147483648) t = -64'sd2147483648;
    r.temperature = t[TEMP_W-1:0];
    return r;
  endfunction

  function automatic void store_point(input request_t rq);
    if (rq.table_id < TTI_CURVES && rq.entry_index < NPTS)
      curve_mem[int'(rq.table_id) * NPTS + int'(rq.entry_index)] = rq.entry_value;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch at result %0d: %s", rx_count, msg);
  endtask

  function automatic void post_request(input request_t rq);
    if (rq.cmd == CMD_LOAD && rq.table_id < TTI_CURVES && rq.entry_index < NPTS)
      gen_pts[int'(rq.table_id) * NPTS + int'(rq.entry_index)] = int'(rq.entry_value);
    req_q.push_back(rq);
    reqs_pending++;
  endfunction

  function automatic request_t load_req(input logic tid, input logic [IDX_W-1:0] idx,
                                        input logic [CODE_W-1:0] val);
    request_t rq;
    rq = '0;
    rq.cmd = CMD_LOAD;
    rq.table_id = tid;
    rq.entry_index = idx;
    rq.entry_value = val;
    rq.sample = SAMPLE_W'($urandom);
    return rq;
  endfunction

  function automatic request_t convert_req(input int smp);
    request_t rq;
    rq = '0;
    rq.cmd = CMD_CONVERT;
    rq.table_id = 1'($urandom);
    rq.entry_index = IDX_W'($urandom);
    rq.entry_value = CODE_W'($urandom);
    rq.sample = smp[SAMPLE_W-1:0];
    return rq;
  endfunction

  task automatic queue_random_curve(input logic tid);
    int v;
    int i;
    int roll;
    v = $urandom_range(0, 3000);
    for (i = 0; i < NPTS; i++) begin
      if (i > 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 4 && v >= 300) v -= $urandom_range(1, 300);
        else if (roll >= 8) v += $urandom_range(200, 1500);
      end
      if (v > 65535) v = 65535;
      post_request(load_req(tid, IDX_W'(i), CODE_W'(v)));
    end
  endtask

  task automatic queue_random_requests(input int count);
    int               base;
    int               a;
    int               b;
    int               k;
    int               pick;
    int               smp;
    int               lo_n;
    int               hi_n;
    logic             tid;
    logic [IDX_W-1:0] idx;
    logic [CODE_W-1:0] val;
    base = int'(gen_sel) * NPTS;
    repeat (count) begin
      if ($urandom_range(0, 99) < 8) begin
        tid = 1'($urandom);
        if ($urandom_range(0, 99) < 85) idx = IDX_W'($urandom_range(0, NPTS - 1));
        else idx = IDX_W'($urandom_range(NPTS, 127));
        val = CODE_W'($urandom);
        if (idx < NPTS && $urandom_range(0, 99) < 70) begin
          lo_n = (idx > 0) ? gen_pts[int'(tid) * NPTS + int'(idx) - 1] : 0;
          hi_n = (idx < NPTS - 1) ? gen_pts[int'(tid) * NPTS + int'(idx) + 1] : 65535;
          if (lo_n <= hi_n) val = CODE_W'($urandom_range(lo_n, hi_n));
        end
        post_request(load_req(tid, idx, val));
      end else begin
        a = gen_pts[base];
        b = gen_pts[base + NPTS - 1];
        if (a > b) begin
          k = a;
          a = b;
          b = k;
        end
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          smp = $urandom_range(a, b);
        end else if (pick < 70) begin
          smp = gen_pts[base + int'($urandom_range(0, NPTS - 1))] + int'($urandom_range(0, 2)) - 1;
        end else if (pick < 82) begin
          smp = last_sample + int'($urandom_range(0, 1000)) - 500;
        end else if (pick < 92) begin
          smp = int'($urandom_range(0, 131071)) - 65536;
        end else begin
          case ($urandom_range(0, 3))
            0: smp = -65536;
            1: smp = 65535;
            2: smp = -1;
            default: smp = 0;
          endcase
        end
        if (smp > 65535) smp = 65535;
        if (smp < -65536) smp = -65536;
        last_sample = smp;
        post_request(convert_req(smp));
      end
    end
  endtask

  task automatic drain();
    while (reqs_pending != 0 || reading_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_couple(input logic sel);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_couple_type <= sel;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sel_curve = sel;
    gen_sel = sel;
  endtask

  // Request side: predict on acceptance, then offer the next request
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        if (cur_req.cmd == CMD_LOAD) begin
          store_point(cur_req);
        end else begin
          predicted = convert_voltage(cur_req.sample);
          reading_q.push_back(cur_req.fixed ? cur_req.lit : predicted);
        end
        tx_count++;
        reqs_pending--;
      end
      if (!in_valid || !in_stall) begin
        if (req_q.size() != 0 &&
            ((tx_count >= 600 && tx_count < 800) || $urandom_range(0, 99) >= 6)) begin
          cur_req = req_q.pop_front();
          in_valid <= 1'b1;
          in_cmd <= cur_req.cmd;
          in_table_id <= cur_req.table_id;
          in_entry_index <= cur_req.entry_index;
          in_entry_value <= cur_req.entry_value;
          in_sample <= cur_req.sample;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side: check in order, stall at random, hold off once
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        rx_count++;
        if (reading_q.size() == 0) begin
          note_mismatch("result with nothing expected");
        end else begin
          want = reading_q.pop_front();
          if (out_temperature !== want.temperature)
            note_mismatch($sformatf("temperature %0d, expected %0d",
                                    out_temperature, want.temperature));
          if (out_clamped_high !== want.clamped_high)
            note_mismatch($sformatf("clamped_high %b, expected %b",
                                    out_clamped_high, want.clamped_high));
          if (out_clamped_low !== want.clamped_low)
            note_mismatch($sformatf("clamped_low %b, expected %b",
                                    out_clamped_low, want.clamped_low));
        end
      end
      if (rx_count == 120 && !held_off) begin
        held_off = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (rx_count >= 400 && rx_count < 550) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 6);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int i;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // J: rising with one flat and one falling segment; K: plain rising
    for (i = 0; i < NPTS; i++) begin
      if (i == 30) post_request(load_req(1'b0, IDX_W'(i), 16'd27100));
      else if (i == 50) post_request(load_req(1'b0, IDX_W'(i), 16'd44800));
      else post_request(load_req(1'b0, IDX_W'(i), CODE_W'(1000 + 900 * i)));
      post_request(load_req(1'b1, IDX_W'(i), CODE_W'(500 + 937 * i)));
    end
    foreach (directed_rows[r]) post_request(directed_rows[r]);
    drain();

    write_couple(1'b1);
    queue_random_requests(370);
    drain();

    write_couple(1'b0);
    queue_random_curve(1'b0);
    queue_random_requests(370);
    drain();

    write_couple(1'b1);
    queue_random_curve(1'b1);
    queue_random_requests(370);
    drain();

    if (mismatch_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
